@@ rtl/core/bchd_pkg.sv @@
// ----------------------------------------------------------------------------
// bchd_pkg
// Shared types, constants and elaboration-time tables for the BCH(63,56)
// single-error decoder.
// ----------------------------------------------------------------------------
package bchd_pkg;

	localparam int WORD_W       = 64;
	localparam int DATA_W       = 56;
	localparam int SYN_W        = 7;
	localparam int POS_W        = 6;
	localparam int CODE_LEN     = 63;
	localparam int SYN_CODES    = 1 << SYN_W;
	localparam int DROPPED_LOW_BITS_DEF = 8;

	// generator x^7 + x^6 + x^2 + 1 without the x^7 term
	localparam logic [SYN_W-1:0] GEN_LOW = 7'h45;

	typedef enum logic [1:0] {
		STATUS_OK        = 2'd0,
		STATUS_CORRECTED = 2'd1,
		STATUS_FAIL      = 2'd2
	} status_t;

	typedef struct packed {
		logic             found;
		logic [POS_W-1:0] pos;
	} loc_t;

	typedef logic [SYN_W-1:0][WORD_W-1:0] syn_cols_t;
	typedef loc_t [SYN_CODES-1:0]         loc_tab_t;

	function automatic logic [SYN_W-1:0] times_x(input logic [SYN_W-1:0] r);
		logic [SYN_W-1:0] t;
		t = {r[SYN_W-2:0], 1'b0};
		if (r[SYN_W-1]) begin
			t = t ^ GEN_LOW;
		end
		return t;
	endfunction

	// column j: which word bits feed syndrome bit j
	function automatic syn_cols_t build_syn_cols();
		syn_cols_t        c;
		logic [SYN_W-1:0] p;
		c = '0;
		p = SYN_W'(1);
		for (int i = 0; i < WORD_W; i++) begin
			for (int j = 0; j < SYN_W; j++) begin
				c[j][i] = p[j];
			end
			p = times_x(p);
		end
		return c;
	endfunction

	// syndrome to lowest bit position with x^i mod g equal to it
	function automatic loc_tab_t build_loc_tab();
		loc_tab_t         t;
		logic [SYN_W-1:0] p [CODE_LEN];
		logic [SYN_W-1:0] r;
		t = '0;
		r = SYN_W'(1);
		for (int i = 0; i < CODE_LEN; i++) begin
			p[i] = r;
			r = times_x(r);
		end
		for (int i = CODE_LEN - 1; i >= 0; i--) begin
			t[p[i]].found = 1'b1;
			t[p[i]].pos   = POS_W'(i);
		end
		return t;
	endfunction

	localparam syn_cols_t SYN_COLS = build_syn_cols();
	localparam loc_tab_t  LOC_TAB  = build_loc_tab();

endpackage

@@ rtl/core/bchd_core.sv @@
// ----------------------------------------------------------------------------
// bchd_core
// Syndrome tree, error locator lookup and bit correction for one codeword.
// ----------------------------------------------------------------------------
module bchd_core import bchd_pkg::*; #(
	parameter int DROPPED_LOW_BITS = DROPPED_LOW_BITS_DEF
) (
	input  logic [WORD_W-1:0] word,
	output logic [DATA_W-1:0] data,
	output status_t           status,
	output logic [SYN_W-1:0]  syndrome
);

	loc_t              loc;
	logic [WORD_W-1:0] fixed;

	always_comb begin
		for (int j = 0; j < SYN_W; j++) begin
			syndrome[j] = ^(word & SYN_COLS[j]);
		end
	end

	assign loc = LOC_TAB[syndrome];

	always_comb begin
		fixed  = word;
		data   = '0;
		status = STATUS_FAIL;
		if (syndrome == '0) begin
			status = STATUS_OK;
			data   = word[DROPPED_LOW_BITS +: DATA_W];
		end else if (loc.found) begin
			status = STATUS_CORRECTED;
			fixed  = word ^ (WORD_W'(1) << loc.pos);
			data   = fixed[DROPPED_LOW_BITS +: DATA_W];
		end
	end

endmodule

@@ rtl/core/bch_63_56_single_error_decoder.sv @@
// ----------------------------------------------------------------------------
// bch_63_56_single_error_decoder
// BCH(63,56) single-error-correcting decoder, one codeword per transaction.
// ----------------------------------------------------------------------------
// Accepts one 64-bit codeword per clock cycle while in_stall is low and
// returns one result per codeword. The codeword is captured in an input
// register. The syndrome xor tree, the 128-entry locator table and the bit
// flip sit between that register and the result register, which presents
// the result. While out_stall holds a result, the input register still takes
// one more codeword. in_stall rises once both registers are full.
module bch_63_56_single_error_decoder import bchd_pkg::*; #(
	parameter int DROPPED_LOW_BITS = DROPPED_LOW_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [WORD_W-1:0] received_word,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [DATA_W-1:0] data_bits,
	output logic [1:0]        decode_status,
	output logic [SYN_W-1:0]  syndrome_value
);

	logic              valid_s1;
	logic [WORD_W-1:0] word_s1;
	logic              valid_s2;
	logic [DATA_W-1:0] data_s2;
	status_t           status_s2;
	logic [SYN_W-1:0]  syn_s2;
	logic              adv;
	logic [DATA_W-1:0] core_data;
	status_t           core_status;
	logic [SYN_W-1:0]  core_syn;

	assign adv      = !valid_s2 || !out_stall;
	assign in_stall = valid_s1 && !adv;

	bchd_core #(
		.DROPPED_LOW_BITS(DROPPED_LOW_BITS)
	) u_core (
		.word     (word_s1),
		.data     (core_data),
		.status   (core_status),
		.syndrome (core_syn)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (!in_stall) begin
				valid_s1 <= in_valid;
			end
			if (adv) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			word_s1 <= received_word;
		end
		if (adv && valid_s1) begin
			data_s2   <= core_data;
			status_s2 <= core_status;
			syn_s2    <= core_syn;
		end
	end

	assign out_valid      = valid_s2;
	assign data_bits      = data_s2;
	assign decode_status  = status_s2;
	assign syndrome_value = syn_s2;

endmodule

@@ rtl/core/bchd_checker.sv @@
// ----------------------------------------------------------------------------
// bchd_checker
// Port-level assertions for the BCH(63,56) decoder, bound to the top level.
// ----------------------------------------------------------------------------
module bchd_checker import bchd_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_stall,
	input logic [WORD_W-1:0] received_word,
	input logic              out_valid,
	input logic              out_stall,
	input logic [DATA_W-1:0] data_bits,
	input logic [1:0]        decode_status,
	input logic [SYN_W-1:0]  syndrome_value
);

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (decode_status == STATUS_OK || decode_status == STATUS_CORRECTED
			|| decode_status == STATUS_FAIL))
		else $error("reserved decode status");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && decode_status == STATUS_FAIL) |-> (data_bits == '0))
		else $error("uncorrectable word with nonzero data");

	a_ok_syndrome: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((decode_status == STATUS_OK) == (syndrome_value == '0)))
		else $error("status and syndrome disagree");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(data_bits)
			&& $stable(decode_status) && $stable(syndrome_value)))
		else $error("stalled transaction changed");

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_stall) |=> (in_valid && $stable(received_word)))
		else $error("stalled input transaction changed");

endmodule

bind bch_63_56_single_error_decoder bchd_checker u_bchd_checker (.*);
